// File: hdl/least_squares_slope_work_function_assert.svh
// assertion macros shared by the checker
`ifndef LEAST_SQUARES_SLOPE_WORK_FUNCTION_ASSERT_SVH
`define LEAST_SQUARES_SLOPE_WORK_FUNCTION_ASSERT_SVH

// checked outside reset
`define LSSW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset too
`define LSSW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hdl/lssw_pkg.sv
`timescale 1ns / 1ps
package lssw_pkg;

  localparam int unsigned InW      = 24;
  localparam int unsigned SumW     = 34;
  localparam int unsigned SqSumW   = 58;
  localparam int unsigned ProdW    = 48;
  localparam int unsigned AccW     = 72;
  localparam int unsigned DvdW     = AccW + 16;
  localparam int unsigned QuoW     = 33;
  localparam int unsigned MulSteps = SumW;
  localparam int unsigned DivSteps = DvdW;
  localparam int unsigned StepW    = 7;

  localparam logic [15:0] GainReset   = 16'd62390;
  localparam logic [31:0] SlopeOne    = 32'h0001_0000;
  localparam logic [31:0] SlopeMaxPos = 32'h7FFF_FFFF;
  localparam logic [31:0] SlopeMaxNeg = 32'h8000_0000;

  // operand pairs of the four fit products
  typedef enum logic [1:0] {
    MUL_N_SZY  = 2'd0,
    MUL_SZ_SY  = 2'd1,
    MUL_N_SZZ  = 2'd2,
    MUL_SZ_SZ  = 2'd3
  } lssw_mul_e;

  typedef struct packed {
    logic      load_pt;
    logic      acc;
    logic      mul_init;
    logic      mul_step;
    logic      mul_store;
    lssw_mul_e mul_sel;
    logic      diff;
    logic      div_init;
    logic      div_step;
    logic      mag;
    logic      sq;
    logic      wf;
    logic      out_load;
  } lssw_cmd_t;

  typedef struct packed {
    logic last_pt;
    logic out_busy;
  } lssw_sts_t;

endpackage

// File: hdl/lssw_ctrl.sv
`timescale 1ns / 1ps
module lssw_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lssw_pkg::lssw_sts_t sts_i,
  output lssw_pkg::lssw_cmd_t cmd_o
);
  import lssw_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_ACC   = 12'b0000_0000_0010,
    S_MINI  = 12'b0000_0000_0100,
    S_MSTEP = 12'b0000_0000_1000,
    S_MSTO  = 12'b0000_0001_0000,
    S_DIFF  = 12'b0000_0010_0000,
    S_DINI  = 12'b0000_0100_0000,
    S_DSTEP = 12'b0000_1000_0000,
    S_MAG   = 12'b0001_0000_0000,
    S_SQ    = 12'b0010_0000_0000,
    S_WF    = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } lssw_state_e;

  lssw_state_e state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  lssw_mul_e sel_q, sel_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.mul_sel = sel_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_pt = 1'b1;
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        sel_d = MUL_N_SZY;
        state_d = sts_i.last_pt ? S_MINI : S_IDLE;
      end
      S_MINI: begin
        cmd_o.mul_init = 1'b1;
        step_d = '0;
        state_d = S_MSTEP;
      end
      S_MSTEP: begin
        cmd_o.mul_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == StepW'(MulSteps - 1)) begin
          state_d = S_MSTO;
        end
      end
      S_MSTO: begin
        cmd_o.mul_store = 1'b1;
        if (sel_q == MUL_SZ_SZ) begin
          state_d = S_DIFF;
        end else begin
          sel_d = lssw_mul_e'(sel_q + 2'd1);
          state_d = S_MINI;
        end
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d = S_DINI;
      end
      S_DINI: begin
        cmd_o.div_init = 1'b1;
        step_d = '0;
        state_d = S_DSTEP;
      end
      S_DSTEP: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == StepW'(DivSteps - 1)) begin
          state_d = S_MAG;
        end
      end
      S_MAG: begin
        cmd_o.mag = 1'b1;
        state_d = S_SQ;
      end
      S_SQ: begin
        cmd_o.sq = 1'b1;
        state_d = S_WF;
      end
      S_WF: begin
        cmd_o.wf = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        // wait for the result register to free up
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      sel_q   <= MUL_N_SZY;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      sel_q   <= sel_d;
    end
  end

endmodule

// File: hdl/lssw_dp.sv
`timescale 1ns / 1ps
module lssw_dp #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lssw_pkg::lssw_cmd_t      cmd_i,
  output lssw_pkg::lssw_sts_t      sts_o,
  input  logic                     cfg_we_i,
  input  logic [15:0]              cfg_wdata_i,
  input  logic signed [23:0]       gap_position_i,
  input  logic signed [23:0]       log_current_i,
  input  logic                     last_point_i,
  input  logic                     out_stall_i,
  output logic                     out_valid_o,
  output logic signed [31:0]       slope_o,
  output logic [31:0]              work_function_o,
  output logic                     degenerate_o,
  output logic                     too_many_points_o
);
  import lssw_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);

  logic [15:0] gain_q;

  // point registers
  logic signed [InW-1:0]   z_q, y_q;
  logic signed [ProdW-1:0] zz_q, zy_q;
  logic                    last_q;

  // running sums
  logic [CntW-1:0]          cnt_q;
  logic signed [SumW-1:0]   sz_q, sy_q;
  logic signed [SqSumW-1:0] szz_q, szy_q;
  logic                     ovf_q;

  // serial multiplier
  logic signed [SumW-1:0]   mul_a;
  logic signed [SqSumW-1:0] mul_b;
  logic [SumW-1:0]          ma_q;
  logic [AccW-1:0]          mb_q, macc_q;
  logic                     aneg_q;
  logic [AccW-1:0]          prod_q [4];

  // divider
  logic [AccW-1:0] num_q, den_q, num_abs;
  logic [DvdW-1:0] dvd_q;
  logic [AccW:0]   rem_q, rem_n;
  logic            rem_ge;
  logic [QuoW-1:0] quo_q;
  logic            sticky_q, big;
  logic            degen_q, sneg_q, neg_q;

  logic [31:0] mag_q;
  logic [63:0] s2_q;
  logic [79:0] wprod;
  logic [31:0] wf_q;

  logic out_valid_q;

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_N_SZY: begin
        mul_a = {{(SumW - CntW){1'b0}}, cnt_q};
        mul_b = szy_q;
      end
      MUL_SZ_SY: begin
        mul_a = sz_q;
        mul_b = {{(SqSumW - SumW){sy_q[SumW-1]}}, sy_q};
      end
      MUL_N_SZZ: begin
        mul_a = {{(SumW - CntW){1'b0}}, cnt_q};
        mul_b = szz_q;
      end
      MUL_SZ_SZ: begin
        mul_a = sz_q;
        mul_b = {{(SqSumW - SumW){sz_q[SumW-1]}}, sz_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign num_abs = num_q[AccW-1] ? (~num_q + 1'b1) : num_q;
  assign rem_n   = {rem_q[AccW-1:0], dvd_q[DvdW-1]};
  assign rem_ge  = (rem_n >= {1'b0, den_q});
  assign big     = sticky_q | quo_q[QuoW-1];
  assign wprod   = s2_q * {{48{1'b0}}, gain_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= GainReset;
      cnt_q       <= '0;
      sz_q        <= '0;
      sy_q        <= '0;
      szz_q       <= '0;
      szy_q       <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        gain_q <= cfg_wdata_i;
      end
      if (cmd_i.load_pt) begin
        last_q <= last_point_i;
      end
      if (cmd_i.acc) begin
        if (cnt_q < CntW'(MAX_POINTS)) begin
          cnt_q <= cnt_q + 1'b1;
          sz_q  <= sz_q + {{(SumW - InW){z_q[InW-1]}}, z_q};
          sy_q  <= sy_q + {{(SumW - InW){y_q[InW-1]}}, y_q};
          szz_q <= szz_q + {{(SqSumW - ProdW){zz_q[ProdW-1]}}, zz_q};
          szy_q <= szy_q + {{(SqSumW - ProdW){zy_q[ProdW-1]}}, zy_q};
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
        cnt_q       <= '0;
        sz_q        <= '0;
        sy_q        <= '0;
        szz_q       <= '0;
        szy_q       <= '0;
        ovf_q       <= 1'b0;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pt) begin
      z_q  <= gap_position_i;
      y_q  <= log_current_i;
      zz_q <= gap_position_i * gap_position_i;
      zy_q <= gap_position_i * log_current_i;
    end
    if (cmd_i.mul_init) begin
      aneg_q <= mul_a[SumW-1];
      ma_q   <= mul_a[SumW-1] ? (~mul_a + 1'b1) : mul_a;
      mb_q   <= {{(AccW - SqSumW){mul_b[SqSumW-1]}}, mul_b};
      macc_q <= '0;
    end
    if (cmd_i.mul_step) begin
      if (ma_q[0]) begin
        macc_q <= macc_q + mb_q;
      end
      mb_q <= mb_q << 1;
      ma_q <= ma_q >> 1;
    end
    if (cmd_i.mul_store) begin
      prod_q[cmd_i.mul_sel] <= aneg_q ? (~macc_q + 1'b1) : macc_q;
    end
    if (cmd_i.diff) begin
      num_q <= prod_q[MUL_N_SZY] - prod_q[MUL_SZ_SY];
      den_q <= prod_q[MUL_N_SZZ] - prod_q[MUL_SZ_SZ];
    end
    if (cmd_i.div_init) begin
      degen_q  <= (den_q == '0) || den_q[AccW-1];
      sneg_q   <= num_q[AccW-1];
      dvd_q    <= {num_abs, 16'h0000};
      rem_q    <= '0;
      quo_q    <= '0;
      sticky_q <= 1'b0;
    end
    if (cmd_i.div_step) begin
      rem_q    <= rem_ge ? (rem_n - {1'b0, den_q}) : rem_n;
      dvd_q    <= dvd_q << 1;
      quo_q    <= {quo_q[QuoW-2:0], rem_ge};
      sticky_q <= sticky_q | quo_q[QuoW-1];
    end
    if (cmd_i.mag) begin
      priority if (degen_q) begin
        mag_q <= SlopeOne;
        neg_q <= 1'b0;
      end else if (sneg_q) begin
        mag_q <= (big || quo_q[31:0] > SlopeMaxNeg) ? SlopeMaxNeg : quo_q[31:0];
        neg_q <= 1'b1;
      end else begin
        mag_q <= (big || quo_q[31]) ? SlopeMaxPos : quo_q[31:0];
        neg_q <= 1'b0;
      end
    end
    if (cmd_i.sq) begin
      s2_q <= {32'h0, mag_q} * {32'h0, mag_q};
    end
    if (cmd_i.wf) begin
      wf_q <= (wprod[79:64] != '0) ? 32'hFFFF_FFFF : wprod[63:32];
    end
    if (cmd_i.out_load) begin
      slope_o           <= neg_q ? (~mag_q + 1'b1) : mag_q;
      work_function_o   <= wf_q;
      degenerate_o      <= degen_q;
      too_many_points_o <= ovf_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.last_pt  = last_q;
  assign sts_o.out_busy = out_valid_q & out_stall_i;

endmodule

// File: hdl/least_squares_slope_work_function.sv
`timescale 1ns / 1ps
// least-squares slope of log current versus tip gap, with a work-function figure
// input channel: one curve point per request (gap_position_i, log_current_i,
// last_point_i), accepted when in_valid_i is high and in_stall_o is low
// a point is latched, and z*z and z*y formed, on acceptance, then added into the
// running sums, and the block takes no new point until the last one is added in
// a point marked last starts the fit: four products by a shift-add multiplier,
// a restoring divider, then saturation, squaring and the gain multiply;
// in_stall_o stays high until the result is in the output register
// output channel: one request per curve on out_valid_o, held while out_stall_i is
// high; a new point is accepted while a result waits, but the next fit's result
// waits in S_OUT until the output register is free
// gain is to be written through cfg_we_i / cfg_wdata_i only while the block is idle;
// the block does not enforce this; reset clears the sums, the count, the overflow
// flag and out_valid_o, and sets gain to its default of 0.952
module least_squares_slope_work_function #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [23:0] gap_position_i,
  input  logic signed [23:0] log_current_i,
  input  logic               last_point_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] slope_o,
  output logic [31:0]        work_function_o,
  output logic               degenerate_o,
  output logic               too_many_points_o
);
  import lssw_pkg::*;

  lssw_cmd_t cmd;
  lssw_sts_t sts;

  lssw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lssw_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .gap_position_i    (gap_position_i),
    .log_current_i     (log_current_i),
    .last_point_i      (last_point_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .slope_o           (slope_o),
    .work_function_o   (work_function_o),
    .degenerate_o      (degenerate_o),
    .too_many_points_o (too_many_points_o)
  );

endmodule

// File: hdl/lssw_chk.sv
`timescale 1ns / 1ps
`include "least_squares_slope_work_function_assert.svh"
module lssw_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] slope_o,
  input logic               degenerate_o
);
  import lssw_pkg::*;

  // a stalled result stays offered
  `LSSW_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped under stall")

  // an accepted point raises in_stall_o, so points are never accepted back to back
  `LSSW_ASSERT(a_in_busy, in_valid_i && !in_stall_o |=> in_stall_o, "point accepted back to back")

  // a zero or negative denominator (degenerate_o) always reports a slope of one
  `LSSW_ASSERT(a_degen_slope, out_valid_o && degenerate_o |-> slope_o == SlopeOne, "slope not one")

  // no result during reset
  `LSSW_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid_o, "result valid in reset")

endmodule

bind least_squares_slope_work_function lssw_chk u_lssw_chk (.*);

// File: tb/sv/tb_least_squares_slope_work_function.sv
`timescale 1ns / 1ps
module tb_least_squares_slope_work_function;
  import lssw_pkg::*;

  localparam int unsigned MaxPoints = 1024;
  localparam int unsigned FitLatency = 300;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned ItemTarget = 1300;

  typedef struct {
    logic [31:0] slope;
    logic [31:0] work_function;
    logic        degenerate;
    logic        too_many_points;
  } fit_result_t;

  class slope_fit_board;
    logic [15:0] gain;
    longint      n, sz, szz, sy, szy;
    bit          overflow;
    fit_result_t pending_fits[$];
    int          errors;

    function new();
      gain = GainReset;
      errors = 0;
      clear();
    endfunction

    function void clear();
      n = 0; sz = 0; szz = 0; sy = 0; szy = 0;
      overflow = 0;
    endfunction

    function void note_point(logic signed [23:0] z_in, logic signed [23:0] y_in,
                             logic last);
      longint z, y;
      logic signed [127:0] wn, wsz, wszz, wsy, wszy, num, den, absnum;
      logic [127:0] quo;
      logic [63:0] mag, sq, wf;
      bit neg, degen;
      fit_result_t r;
      z = z_in;
      y = y_in;
      if (n < MaxPoints) begin
        n++;
        sz += z;
        szz += z * z;
        sy += y;
        szy += z * y;
      end else begin
        overflow = 1;
      end
      if (!last) return;
      wn = n; wsz = sz; wszz = szz; wsy = sy; wszy = szy;
      num = wn * wszy - wsz * wsy;
      den = wn * wszz - wsz * wsz;
      degen = (den <= 0);
      neg = 0;
      if (degen) begin
        mag = 64'(SlopeOne);
      end else begin
        neg = (num < 0);
        absnum = neg ? -num : num;
        quo = $unsigned(absnum <<< 16) / $unsigned(den);
        if (neg)
          mag = (quo > 128'(SlopeMaxNeg)) ? 64'(SlopeMaxNeg) : quo[63:0];
        else
          mag = (quo > 128'(SlopeMaxPos)) ? 64'(SlopeMaxPos) : quo[63:0];
      end
      sq = mag * mag;
      wf = (sq >> 32) * gain + (((sq & 64'hFFFF_FFFF) * gain) >> 32);
      r.slope = neg ? 32'(-mag) : mag[31:0];
      r.work_function = (wf > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wf[31:0];
      r.degenerate = degen;
      r.too_many_points = overflow;
      pending_fits = {pending_fits, r};
      clear();
    endfunction

    function void check_result(fit_result_t got);
      fit_result_t exp_r;
      if (pending_fits.size() == 0) begin
        $display("%0t: unexpected result slope=%h", $time, got.slope);
        errors++;
        return;
      end
      exp_r = pending_fits.pop_front();
      if (got.slope !== exp_r.slope) begin
        $display("%0t: slope expected %h actual %h", $time, exp_r.slope, got.slope);
        errors++;
      end
      if (got.work_function !== exp_r.work_function) begin
        $display("%0t: work_function expected %h actual %h", $time,
                 exp_r.work_function, got.work_function);
        errors++;
      end
      if (got.degenerate !== exp_r.degenerate) begin
        $display("%0t: degenerate expected %b actual %b", $time,
                 exp_r.degenerate, got.degenerate);
        errors++;
      end
      if (got.too_many_points !== exp_r.too_many_points) begin
        $display("%0t: too_many_points expected %b actual %b", $time,
                 exp_r.too_many_points, got.too_many_points);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [15:0]        cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [23:0] gap_position_i;
  logic signed [23:0] log_current_i;
  logic               last_point_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] slope_o;
  logic [31:0]        work_function_o;
  logic               degenerate_o;
  logic               too_many_points_o;

  slope_fit_board fits = new();
  bit  quiet = 0;
  int  items_sent = 0;
  int  stall_left = 0;
  int  cycles = 0;

  least_squares_slope_work_function #(
    .MAX_POINTS(MaxPoints)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .gap_position_i    (gap_position_i),
    .log_current_i     (log_current_i),
    .last_point_i      (last_point_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .slope_o           (slope_o),
    .work_function_o   (work_function_o),
    .degenerate_o      (degenerate_o),
    .too_many_points_o (too_many_points_o)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // result side: random stall bursts, checking every accepted request
  always @(posedge clk_i) begin
    fit_result_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.slope = slope_o;
        got.work_function = work_function_o;
        got.degenerate = degenerate_o;
        got.too_many_points = too_many_points_o;
        fits.check_result(got);
      end
      if (stall_left > 0)
        stall_left--;
      else if (!quiet && $urandom_range(0, 4) == 0)
        stall_left = $urandom_range(1, 6);
      out_stall_i <= (stall_left > 0);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("least_squares_slope_work_function: mismatch");
      $finish;
    end
  end

  task automatic send_point(logic signed [23:0] z, logic signed [23:0] y, logic last);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    gap_position_i <= z;
    log_current_i <= y;
    last_point_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    fits.note_point(z, y, last);
    items_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (fits.pending_fits.size() != 0) @(posedge clk_i);
    repeat (FitLatency) @(posedge clk_i);
  endtask

  task automatic write_gain(logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    fits.gain = value;
  endtask

  function automatic logic signed [23:0] pick_value();
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(0, 8000)) - 4000);
      2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($signed($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  task automatic send_curve(int len);
    logic signed [23:0] z0, slope_k, base;
    bit flat;
    flat = ($urandom_range(0, 19) == 0);
    z0 = pick_value();
    slope_k = 24'($signed($urandom_range(0, 64)) - 32);
    base = pick_value();
    for (int i = 0; i < len; i++) begin
      if (flat)
        send_point(z0, pick_value(), i == len - 1);
      else if ($urandom_range(0, 2) == 0)
        send_point(pick_value(), pick_value(), i == len - 1);
      else
        send_point(24'(z0 + i * 409), 24'(base + slope_k * i * 409 / 16
                   + $signed($urandom_range(0, 64)) - 32), i == len - 1);
    end
  endtask

  initial begin
    int len;
    int base_items;
    rst_ni = 1'b1;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    gap_position_i = '0;
    log_current_i = '0;
    last_point_i = 1'b0;
    #1;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single point, then all z equal: zero denominator
    send_point(24'h7FFFFF, 24'h800000, 1'b1);
    send_point(24'h000123, 24'h7FFFFF, 1'b0);
    send_point(24'h000123, 24'h800000, 1'b1);
    // steep rise and fall saturate the slope
    send_point(24'h000000, 24'h800000, 1'b0);
    send_point(24'h000001, 24'h7FFFFF, 1'b1);
    send_point(24'h000000, 24'h7FFFFF, 1'b0);
    send_point(24'h000001, 24'h800000, 1'b1);
    // full-scale z and y
    send_point(24'h800000, 24'h7FFFFF, 1'b0);
    send_point(24'h7FFFFF, 24'h800000, 1'b0);
    send_point(24'h000000, 24'h000000, 1'b1);
    send_point(24'h001000, 24'hFFE000, 1'b0);
    send_point(24'h002000, 24'hFFC100, 1'b0);
    send_point(24'h003000, 24'hFFA000, 1'b1);
    // curve longer than the point limit, then the next curve starts clean
    for (int i = 0; i < MaxPoints + 3; i++)
      send_point(24'(i * 16), 24'(-i * 37), i == MaxPoints + 2);
    send_point(24'h000010, 24'h000020, 1'b0);
    send_point(24'h000030, 24'h000010, 1'b1);

    // spread the remaining points over the four gain settings
    base_items = items_sent;
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0: write_gain(16'h0000);
        1: write_gain(16'hFFFF);
        2: write_gain(16'($urandom));
        default: write_gain(GainReset);
      endcase
      while (items_sent < base_items + (ItemTarget - base_items) * (phase + 1) / 4) begin
        if (phase == 3 && items_sent > ItemTarget - 40) quiet = 1;
        len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 40);
        send_curve(len);
      end
    end

    settle();
    if (fits.errors == 0)
      $display("least_squares_slope_work_function: match");
    else
      $display("least_squares_slope_work_function: mismatch");
    $finish;
  end

endmodule
